// File: rtl/first_fit_wait_queue_core_defines.svh
// Assertion macros shared by the first-fit wait queue checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FIRST_FIT_WAIT_QUEUE_CORE_DEFINES_SVH
`define FIRST_FIT_WAIT_QUEUE_CORE_DEFINES_SVH

// Sequence or implication property, checked on every clock outside reset.
`define FFQ_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Plain condition that must hold at every clock outside reset.
`define FFQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`endif

// File: rtl/ffq_pkg.sv
// Package for the first-fit wait queue: widths, beat layouts, opcode and
// result codes, and the controller/datapath command and status structs.
// No dependencies.
package ffq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int ID_W        = 16;
  localparam int SIZE_W      = 8;
  localparam int STAT_W      = 4;
  localparam int AHEAD_W     = 6;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = ID_W + SIZE_W + STAT_W;

  // Input beat: op, group_id, group_size, status_in from bit 0 up.
  localparam int IN_OP_LO   = 0;
  localparam int IN_ID_LO   = 2;
  localparam int IN_SIZE_LO = IN_ID_LO + ID_W;
  localparam int IN_STAT_LO = IN_SIZE_LO + SIZE_W;
  localparam int IN_BITS    = IN_STAT_LO + STAT_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Output beat: result_code, id_out, present, ahead_count from bit 0 up.
  localparam int OUT_RC_LO    = 0;
  localparam int OUT_ID_LO    = 2;
  localparam int OUT_PRES_LO  = OUT_ID_LO + ID_W;
  localparam int OUT_AHEAD_LO = OUT_PRES_LO + 1;
  localparam int OUT_BITS     = OUT_AHEAD_LO + AHEAD_W;
  localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [STAT_W-1:0] STATUS_WAITING = '0;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_TAKE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_SET    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RC_DONE      = 2'd0,
    RC_NOT_FOUND = 2'd1,
    RC_WAITING   = 2'd2,
    RC_FULL      = 2'd3
  } rc_e;

  typedef struct packed {
    logic load;       // capture the input beat, restart the scan pointer
    logic issue;      // read the entry at the scan pointer, advance it
    logic wr_append;  // write the held item at the back
    logic wr_status;  // rewrite the status of the checked entry
    logic wr_shift;   // move the checked entry down by one slot
    logic fill_inc;
    logic fill_dec;
    logic stage_en;   // capture a result
    rc_e  stage_code;
    logic out_load;   // move the captured result to the output register
  } ffq_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic ptr_end;    // every live entry has been read
    logic chk_valid;  // read data holds an entry this cycle
    logic hit;        // that entry matches the held operation
    logic waiting;    // that entry has waiting status
  } ffq_stat_t;

endpackage

// File: rtl/ffq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ffq_ctrl.sv
// Controller of the first-fit wait queue: sequences scans, compaction and
// result hand-off. Depends on ffq_pkg.
module ffq_ctrl
  import ffq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  output logic      m_axis_tvalid_o,
  input  logic      m_axis_tready_i,
  input  ffq_stat_t stat_i,
  output ffq_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_POST  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.stage_code = RC_NOT_FOUND;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.op == OP_APPEND) begin
          cmd_o.stage_en = 1'b1;
          if (stat_i.full) begin
            cmd_o.stage_code = RC_FULL;
          end else begin
            cmd_o.wr_append  = 1'b1;
            cmd_o.fill_inc   = 1'b1;
            cmd_o.stage_code = RC_DONE;
          end
          state_d = S_POST;
        end else if (stat_i.chk_valid && stat_i.hit) begin
          cmd_o.stage_en   = 1'b1;
          cmd_o.stage_code = RC_DONE;
          case (stat_i.op)
            OP_TAKE: begin
              // keep reading: the entries behind the hit move down
              cmd_o.issue = !stat_i.ptr_end;
              state_d     = S_SHIFT;
            end
            OP_SET: begin
              if (stat_i.waiting) begin
                cmd_o.stage_code = RC_WAITING;
              end else begin
                cmd_o.wr_status = 1'b1;
              end
              state_d = S_POST;
            end
            default: begin
              state_d = S_POST;
            end
          endcase
        end else if (!stat_i.chk_valid && stat_i.ptr_end) begin
          cmd_o.stage_en   = 1'b1;
          cmd_o.stage_code = RC_NOT_FOUND;
          state_d          = S_POST;
        end else begin
          cmd_o.issue = !stat_i.ptr_end;
        end
      end
      S_SHIFT: begin
        cmd_o.wr_shift = stat_i.chk_valid;
        cmd_o.issue    = !stat_i.ptr_end;
        if (!stat_i.chk_valid && stat_i.ptr_end) begin
          cmd_o.fill_dec = 1'b1;
          state_d        = S_POST;
        end
      end
      S_POST: begin
        if (!out_valid_q || m_axis_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;

endmodule

// File: rtl/ffq_dp.sv
// Datapath of the first-fit wait queue: item and result registers, the
// entry RAM, fill level, scan pointer and match logic. Depends on ffq_pkg, ffq_ram.
module ffq_dp
  import ffq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  ffq_cmd_t              cmd_i,
  output ffq_stat_t             stat_o
);

  // held item
  op_e               op_q;
  logic [ID_W-1:0]   id_q;
  logic [SIZE_W-1:0] sz_q;
  logic [STAT_W-1:0] st_q;

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             chk_valid_q;
  logic [IDX_W-1:0] chk_idx_q;

  // staged and output results
  rc_e                res_code_q, out_code_q;
  logic [ID_W-1:0]    res_id_q, out_id_q;
  logic               res_pres_q, out_pres_q;
  logic [AHEAD_W-1:0] res_ahead_q, out_ahead_q;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [ID_W-1:0]    rd_id;
  logic [SIZE_W-1:0]  rd_size;
  logic [STAT_W-1:0]  rd_stat;
  logic               stage_pres;

  // entry layout: status, size, id from the top down
  assign rd_id   = rdata[ID_W-1:0];
  assign rd_size = rdata[ID_W +: SIZE_W];
  assign rd_stat = rdata[ID_W + SIZE_W +: STAT_W];

  always_comb begin
    we    = cmd_i.wr_append | cmd_i.wr_status | cmd_i.wr_shift;
    waddr = fill_q[IDX_W-1:0];
    wdata = {st_q, sz_q, id_q};
    if (cmd_i.wr_status) begin
      waddr = chk_idx_q;
      wdata = {st_q, rd_size, rd_id};
    end else if (cmd_i.wr_shift) begin
      waddr = chk_idx_q - IDX_W'(1);
      wdata = rdata;
    end
  end

  ffq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_inc) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_q - CNT_W'(1);
    end
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      ptr_d = '0;
    end else if (cmd_i.issue) begin
      ptr_d = ptr_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ptr_q       <= '0;
      chk_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      chk_valid_q <= cmd_i.issue;
    end
  end

  assign stage_pres = (cmd_i.stage_code == RC_DONE) && (op_q == OP_QUERY);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(s_axis_tdata_i[IN_OP_LO +: 2]);
      id_q <= s_axis_tdata_i[IN_ID_LO +: ID_W];
      sz_q <= s_axis_tdata_i[IN_SIZE_LO +: SIZE_W];
      st_q <= s_axis_tdata_i[IN_STAT_LO +: STAT_W];
    end
    if (cmd_i.issue) begin
      chk_idx_q <= ptr_q[IDX_W-1:0];
    end
    if (cmd_i.stage_en) begin
      res_code_q  <= cmd_i.stage_code;
      res_id_q    <= ((cmd_i.stage_code == RC_DONE) && (op_q == OP_TAKE)) ? rd_id : '0;
      res_pres_q  <= stage_pres;
      res_ahead_q <= stage_pres ? AHEAD_W'(chk_idx_q) : '0;
    end
    if (cmd_i.out_load) begin
      out_code_q  <= res_code_q;
      out_id_q    <= res_id_q;
      out_pres_q  <= res_pres_q;
      out_ahead_q <= res_ahead_q;
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.full      = (fill_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.ptr_end   = (ptr_q >= fill_q);
  assign stat_o.chk_valid = chk_valid_q;
  assign stat_o.hit       = (op_q == OP_TAKE) ? (rd_size <= sz_q) : (rd_id == id_q);
  assign stat_o.waiting   = (rd_stat == STATUS_WAITING);

  assign m_axis_tdata_o = {(OUT_DATA_W - OUT_BITS)'(0), out_ahead_q, out_pres_q,
                           out_id_q, out_code_q};

endmodule

// File: rtl/first_fit_wait_queue_core.sv
// First-fit wait queue, top level: joins the controller and the datapath.
// Depends on ffq_pkg, ffq_ctrl, ffq_dp.
//
// Usage:
//   Slave stream carries one operation per beat: append, take first fit,
//   query position or set status. Master stream returns exactly one result
//   beat per operation, in order.
//   Entries live in a 32-entry RAM with one read and one write port; the scan
//   reads one entry per cycle, and a take moves every entry behind the
//   removed one down by one slot over the same read stream.
//   Append is decided without reading the RAM; the other operations read
//   entries in order until a hit or the end of the queue, and a take reads
//   on to the end whether the hit is early or late. A result is captured in
//   a staging register, then moved to the output register; the scan length
//   sets how soon the next beat can be taken.
//   One operation is in flight at a time; the next beat is accepted once the
//   result has been moved to the output register, so a result waiting on a
//   stalled receiver does not hold off the next operation, only its result.
//   Reset empties the queue at once; entry contents are left as they are and
//   are never read before being written.
//   tdata is idle-safe: it holds while tvalid is high and tready is low.
module first_fit_wait_queue_core
  import ffq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // op [1:0], group_id [17:2], group_size [25:18], status_in [29:26]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // result_code [1:0], id_out [17:2], present [18], ahead_count [24:19]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  ffq_cmd_t  cmd;
  ffq_stat_t stat;

  ffq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  ffq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tdata_o (m_axis_tdata),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

// File: rtl/ffq_checker.sv
// Port-level checker for the first-fit wait queue, bound to the top level.
// Depends on ffq_pkg and first_fit_wait_queue_core_defines.svh.
`include "first_fit_wait_queue_core_defines.svh"

module ffq_checker
  import ffq_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic               in_beat;
  logic               out_beat;
  logic               out_stall;
  logic [1:0]         rc;
  logic               pres;
  logic [ID_W-1:0]    id_out;
  logic [AHEAD_W-1:0] ahead;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_beat  = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign rc        = m_axis_tdata[OUT_RC_LO +: 2];
  assign pres      = m_axis_tdata[OUT_PRES_LO];
  assign id_out    = m_axis_tdata[OUT_ID_LO +: ID_W];
  assign ahead     = m_axis_tdata[OUT_AHEAD_LO +: AHEAD_W];

  // a stalled result holds
  `FFQ_ASSERT_PROP(a_out_hold, (out_stall |=> m_axis_tvalid && $stable(m_axis_tdata)),
                   "stalled result beat changed")
  // one operation at a time: no beat accepted right after another
  `FFQ_ASSERT_PROP(a_one_in_flight, (in_beat |=> !s_axis_tready),
                   "input accepted while an operation is in flight")
  // a position only with presence; a failed operation reports no presence or id
  `FFQ_ASSERT_ALWAYS(a_pres_done, (!out_beat || pres || ahead == '0),
                     "ahead count without presence")
  `FFQ_ASSERT_ALWAYS(a_id_done, (!out_beat || rc == RC_DONE || (!pres && id_out == '0)),
                     "fields set on a failed operation")

endmodule

bind first_fit_wait_queue_core ffq_checker u_ffq_checker (.*);

// File: tb/sv/first_fit_wait_queue_core_tb.sv
// Self-checking testbench for first_fit_wait_queue_core: drives op beats,
// predicts each result beat with an in-bench copy of the queue and compares.
// Depends on ffq_pkg and the first_fit_wait_queue_core RTL.
module first_fit_wait_queue_core_tb
  import ffq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM   = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + 24;
  localparam int HOLD_AT_OPS  = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 15;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   group_id;
    logic [SIZE_W-1:0] group_size;
    logic [STAT_W-1:0] status_in;
  } op_item_t;

  typedef struct packed {
    rc_e                code;
    logic [ID_W-1:0]    id_out;
    logic               present;
    logic [AHEAD_W-1:0] ahead;
  } reply_t;

  // Tracks the queue contents and the replies still owed by the block.
  class wait_queue_tracker;
    logic [ID_W-1:0]   held_ident[QUEUE_DEPTH];
    logic [SIZE_W-1:0] held_size[QUEUE_DEPTH];
    logic [STAT_W-1:0] held_status[QUEUE_DEPTH];
    int unsigned       fill;
    int unsigned       mismatches;
    reply_t            owed_replies[$];

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction

    // Oldest slot holding this id, or fill if absent.
    function int unsigned locate(logic [ID_W-1:0] id);
      for (int unsigned k = 0; k < fill; k++) begin
        if (held_ident[k] == id) return k;
      end
      return fill;
    endfunction

    function void note_op(op_item_t it);
      reply_t      r;
      int unsigned k;
      r = '{code: RC_NOT_FOUND, id_out: '0, present: 1'b0, ahead: '0};
      case (it.op)
        OP_APPEND: begin
          if (fill >= QUEUE_DEPTH) begin
            r.code = RC_FULL;
          end else begin
            held_ident[fill]  = it.group_id;
            held_size[fill]   = it.group_size;
            held_status[fill] = it.status_in;
            fill++;
            r.code = RC_DONE;
          end
        end
        OP_TAKE: begin
          for (k = 0; k < fill; k++) begin
            if (held_size[k] <= it.group_size) break;
          end
          if (k < fill) begin
            r.id_out = held_ident[k];
            // compact everything behind the removed entry
            for (; k + 1 < fill; k++) begin
              held_ident[k]  = held_ident[k+1];
              held_size[k]   = held_size[k+1];
              held_status[k] = held_status[k+1];
            end
            fill--;
            r.code = RC_DONE;
          end
        end
        OP_QUERY: begin
          k = locate(it.group_id);
          if (k < fill) begin
            r.present = 1'b1;
            r.ahead   = AHEAD_W'(k);
            r.code    = RC_DONE;
          end
        end
        default: begin
          k = locate(it.group_id);
          if (k < fill) begin
            if (held_status[k] == STATUS_WAITING) begin
              r.code = RC_WAITING;
            end else begin
              held_status[k] = it.status_in;
              r.code = RC_DONE;
            end
          end
        end
      endcase
      owed_replies.push_back(r);
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] d);
      reply_t want;
      reply_t got;
      got.code    = rc_e'(d[OUT_RC_LO +: 2]);
      got.id_out  = d[OUT_ID_LO +: ID_W];
      got.present = d[OUT_PRES_LO];
      got.ahead   = d[OUT_AHEAD_LO +: AHEAD_W];
      if (owed_replies.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0h", $realtime, d);
        mismatches++;
        return;
      end
      want = owed_replies.pop_front();
      if (got.code !== want.code) begin
        $display("%0t: result_code expected %0d actual %0d", $realtime, want.code, got.code);
        mismatches++;
      end
      if (got.id_out !== want.id_out) begin
        $display("%0t: id_out expected %0h actual %0h", $realtime, want.id_out, got.id_out);
        mismatches++;
      end
      if (got.present !== want.present) begin
        $display("%0t: present expected %0b actual %0b", $realtime, want.present, got.present);
        mismatches++;
      end
      if (got.ahead !== want.ahead) begin
        $display("%0t: ahead_count expected %0d actual %0d", $realtime, want.ahead, got.ahead);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  wait_queue_tracker tracker = new();
  int unsigned       ops_sent = 0;
  bit                steady   = 1'b0;

  first_fit_wait_queue_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [IN_DATA_W-1:0] pack_op(op_item_t it);
    logic [IN_DATA_W-1:0] v;
    v = '0;
    v[IN_OP_LO +: 2]        = it.op;
    v[IN_ID_LO +: ID_W]     = it.group_id;
    v[IN_SIZE_LO +: SIZE_W] = it.group_size;
    v[IN_STAT_LO +: STAT_W] = it.status_in;
    return v;
  endfunction

  function automatic op_item_t make_op(op_e op, logic [ID_W-1:0] id,
                                       logic [SIZE_W-1:0] sz, logic [STAT_W-1:0] st);
    op_item_t it;
    it.op         = op;
    it.group_id   = id;
    it.group_size = sz;
    it.status_in  = st;
    return it;
  endfunction

  // Phases swing the mix between filling and draining so that both the
  // full and the empty queue come up often.
  function automatic op_item_t next_random_op(int idx);
    int       append_pct[4] = '{65, 35, 15, 35};
    op_item_t it;
    int       r;
    r = $urandom_range(99);
    if (r < append_pct[(idx / 90) % 4]) begin
      it.op = OP_APPEND;
    end else begin
      case ($urandom_range(2))
        0:       it.op = OP_TAKE;
        1:       it.op = OP_QUERY;
        default: it.op = OP_SET;
      endcase
    end
    r = $urandom_range(99);
    if (r < 45 && tracker.fill > 0) begin
      it.group_id = tracker.held_ident[$urandom_range(tracker.fill - 1)];
    end else if (r < 70) begin
      it.group_id = ID_W'($urandom_range(7));
    end else begin
      it.group_id = ID_W'($urandom);
    end
    r = $urandom_range(99);
    if (it.op == OP_TAKE && r < 30 && tracker.fill > 0) begin
      it.group_size = tracker.held_size[$urandom_range(tracker.fill - 1)];
    end else if (r < 45) begin
      it.group_size = ($urandom_range(1) == 0) ? '0 : '1;
    end else begin
      it.group_size = SIZE_W'($urandom);
    end
    it.status_in = ($urandom_range(99) < 30) ? STATUS_WAITING : STAT_W'($urandom);
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat
  // is accepted, with tvalid still high.
  task automatic issue_op(op_item_t it);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tdata  <= pack_op(it);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_op(it);
    ops_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    op_item_t directed[$];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty queue, extremes, duplicates, waiting entries, first-fit order
    directed.push_back(make_op(OP_TAKE,   16'h0000, 8'hFF, 4'h0));
    directed.push_back(make_op(OP_QUERY,  16'h0000, 8'h00, 4'h0));
    directed.push_back(make_op(OP_SET,    16'hFFFF, 8'h00, 4'hF));
    directed.push_back(make_op(OP_APPEND, 16'hFFFF, 8'hFF, 4'hF));
    directed.push_back(make_op(OP_APPEND, 16'h0000, 8'h00, STATUS_WAITING));
    directed.push_back(make_op(OP_APPEND, 16'hFFFF, 8'h80, 4'h5));
    directed.push_back(make_op(OP_APPEND, 16'hA5A5, 8'h55, 4'hA));
    directed.push_back(make_op(OP_QUERY,  16'hFFFF, 8'h00, 4'h0));
    directed.push_back(make_op(OP_QUERY,  16'h0000, 8'hFF, 4'hF));
    directed.push_back(make_op(OP_QUERY,  16'hA5A5, 8'h00, 4'h0));
    directed.push_back(make_op(OP_QUERY,  16'h1234, 8'h00, 4'h0));
    directed.push_back(make_op(OP_SET,    16'h0000, 8'h00, 4'h3));
    directed.push_back(make_op(OP_SET,    16'hFFFF, 8'hFF, STATUS_WAITING));
    directed.push_back(make_op(OP_SET,    16'hFFFF, 8'h00, 4'h9));
    directed.push_back(make_op(OP_SET,    16'hA5A5, 8'h00, 4'h6));
    directed.push_back(make_op(OP_SET,    16'h5A5A, 8'h00, 4'h6));
    directed.push_back(make_op(OP_TAKE,   16'h0000, 8'h00, 4'h0));
    directed.push_back(make_op(OP_TAKE,   16'hFFFF, 8'hFE, 4'hF));
    directed.push_back(make_op(OP_TAKE,   16'h0000, 8'h54, 4'h0));
    directed.push_back(make_op(OP_TAKE,   16'h0000, 8'hFF, 4'h0));
    directed.push_back(make_op(OP_TAKE,   16'h0000, 8'hFF, 4'h0));
    directed.push_back(make_op(OP_TAKE,   16'h0000, 8'hFF, 4'h0));
    foreach (directed[k]) issue_op(directed[k]);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      steady = (i >= 250 && i < 380);
      issue_op(next_random_op(i));
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random stalls plus one long hold-off that backs the block up.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && ops_sent >= HOLD_AT_OPS) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      m_axis_tready <= rst_ni && hold_left == 0 &&
                       (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_reply(m_axis_tdata);
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ffq_pkg.sv
rtl/ffq_ram.sv
rtl/ffq_ctrl.sv
rtl/ffq_dp.sv
rtl/first_fit_wait_queue_core.sv
rtl/ffq_checker.sv
tb/sv/first_fit_wait_queue_core_tb.sv
